// ===== design/tpba_pkg.sv =====
`timescale 1ns / 1ps

package tpba_pkg;

  // fixed field widths
  localparam int BASE_W  = 47;
  localparam int ADDR_W  = 48;
  localparam int TAG_W   = 32;
  localparam int SIZE_W  = 17;
  localparam int ALIGN_W = 5;
  localparam int CIDX_W  = 3;
  localparam int STAT_W  = 2;
  localparam int FREED_W = 7;
  localparam int PAD_W   = 32;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERSIZE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_LOOK,
    S_A_FIT,
    S_N_ADDR,
    S_N_FIT,
    S_F_READ,
    S_F_TAG,
    S_F_CHK,
    S_F_LAST
  } state_t;

endpackage

// ===== design/tagged_page_bump_allocator.sv =====
`timescale 1ns / 1ps

// Tagged page bump allocator. An item is taken when start is high and busy is
// low; its single result shows on the out_ ports for one cycle with out_valid,
// and the receiver cannot stall it. Page fill, page tags, the used list and the
// free stack sit in synchronous memories with registered reads, and every item
// is a short read-modify-write sequence over them. An allocate that fits the
// active page passes the lookup and fit states; one that needs a new page passes
// the new-page address and fit states, after the lookup when an active page
// exists, and is refused there if the pool is exhausted or the request does not
// fit a fresh page; an oversize request is refused when accepted. A free-tag item
// walks the used list and frees each listed page whose tag matches.
// No clearing pass is needed after reset; only pages already handed out are
// ever read back.
module tagged_page_bump_allocator #(
  parameter int PAGE_BYTES = 65536,
  parameter int NUM_PAGES  = 64,
  parameter int NUM_CACHES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [tpba_pkg::CIDX_W-1:0]   in_cache_index,
  input  logic [tpba_pkg::TAG_W-1:0]    in_tag,
  input  logic [tpba_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [tpba_pkg::ALIGN_W-1:0]  in_align_log2,
  output logic                          out_valid,
  output logic [tpba_pkg::STAT_W-1:0]   out_status,
  output logic [tpba_pkg::ADDR_W-1:0]   out_address,
  output logic [tpba_pkg::FREED_W-1:0]  out_pages_freed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpba_pkg::BASE_W-1:0]   cfg_data
);
  import tpba_pkg::*;

  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;
  localparam int FW = $clog2(PAGE_BYTES) + 1;
  localparam int SUM_W = PAD_W + 2;
  localparam logic [PW:0]       NUM_PAGES_C = (PW + 1)'(NUM_PAGES);
  localparam logic [SUM_W-1:0]  PAGE_SUM    = SUM_W'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_ADDR   = ADDR_W'(PAGE_BYTES);

  // page memories
  logic [FW-1:0]    fill_mem [NUM_PAGES];
  logic [TAG_W-1:0] tag_mem  [NUM_PAGES];
  logic [PW-1:0]    ul_mem   [NUM_PAGES];
  logic [PW-1:0]    fs_mem   [NUM_PAGES];

  state_t state_r, state_nxt;

  logic [BASE_W-1:0] base_r;
  logic [CW-1:0]     c_r;
  logic [TAG_W-1:0]  tag_r;
  logic [SIZE_W-1:0] size_r;
  logic [ALIGN_W-1:0] lg_r;
  logic [PW:0]       used_count_r, free_count_r, fresh_next_r, walk_i_r, freed_r;
  logic              cvalid_r [NUM_CACHES];
  logic [PW-1:0]     cpage_r  [NUM_CACHES];
  logic [ADDR_W-1:0] pa_r, addr_r;
  logic [PW-1:0]     newp_r;
  logic              from_stack_r;
  logic [FW-1:0]     fill_rd;
  logic [TAG_W-1:0]  tag_rd;
  logic [PW-1:0]     ul_rd, fs_rd;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_address_r, out_address_nxt;
  logic [FREED_W-1:0] out_freed_r, out_freed_nxt;

  logic              accept;
  logic [CW-1:0]     cidx, csel;
  logic [PW-1:0]     fill_ra, ul_ra, fs_ra, cand_p;
  logic [PAD_W-1:0]  amask, pad;
  logic [SUM_W-1:0]  sum_act, sum_new;
  logic              fits_act, fits_new, have_stack, have_fresh, oversize, tag_hit;

  // cache index reduced modulo the cache count
  function automatic logic [CW-1:0] cache_mod(input logic [CIDX_W-1:0] v);
    logic [CIDX_W:0] r;
    r = {1'b0, v};
    for (int k = 0; k < (1 << CIDX_W); k++) begin
      if (r >= (CIDX_W + 1)'(NUM_CACHES)) r = r - (CIDX_W + 1)'(NUM_CACHES);
    end
    return CW'(r);
  endfunction

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cidx      = cache_mod(in_cache_index);
  assign csel      = (state_r == S_IDLE) ? cidx : c_r;

  // read addresses
  assign fill_ra = cpage_r[csel];
  assign fs_ra   = PW'(free_count_r - 1'b1);
  assign ul_ra   = (state_r == S_F_CHK) ? PW'(used_count_r - 1'b1) : PW'(walk_i_r);

  // alignment pad and fit checks
  assign amask    = ~({PAD_W{1'b1}} << lg_r);
  assign pad      = PAD_W'(ADDR_W'(0) - addr_r) & amask;
  assign sum_act  = SUM_W'(fill_rd) + SUM_W'(size_r) + SUM_W'(pad);
  assign sum_new  = SUM_W'(size_r) + SUM_W'(pad);
  assign fits_act = (sum_act <= PAGE_SUM);
  assign fits_new = (sum_new <= PAGE_SUM);
  assign have_stack = (free_count_r != '0);
  assign have_fresh = (fresh_next_r < NUM_PAGES_C);
  assign cand_p   = have_stack ? fs_rd : PW'(fresh_next_r);
  assign oversize = (SUM_W'(in_size_bytes) > PAGE_SUM);
  assign tag_hit  = (tag_rd == tag_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_FREE) state_nxt = S_F_READ;
          else if (oversize) state_nxt = S_IDLE;
          else if (cvalid_r[cidx]) state_nxt = S_A_LOOK;
          else state_nxt = S_N_ADDR;
        end
      end
      S_A_LOOK: state_nxt = S_A_FIT;
      S_A_FIT:  state_nxt = fits_act ? S_IDLE : S_N_ADDR;
      S_N_ADDR: state_nxt = (have_stack || have_fresh) ? S_N_FIT : S_IDLE;
      S_N_FIT:  state_nxt = S_IDLE;
      S_F_READ: state_nxt = (walk_i_r < used_count_r) ? S_F_TAG : S_IDLE;
      S_F_TAG:  state_nxt = S_F_CHK;
      S_F_CHK:  state_nxt = tag_hit ? S_F_LAST : S_F_READ;
      S_F_LAST: state_nxt = S_F_READ;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy            = (state_r != S_IDLE);
    out_valid       = out_valid_r;
    out_status      = out_status_r;
    out_address     = out_address_r;
    out_pages_freed = out_freed_r;
  end

  // result payload
  always_comb begin
    out_status_nxt  = ST_OK;
    out_address_nxt = '0;
    out_freed_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_operation == OP_ALLOC && oversize) out_status_nxt = ST_OVERSIZE;
      end
      S_A_FIT:  if (fits_act) out_address_nxt = addr_r + ADDR_W'(pad);
      S_N_ADDR: if (!have_stack && !have_fresh) out_status_nxt = ST_EXHAUSTED;
      S_N_FIT: begin
        if (fits_new) out_address_nxt = addr_r + ADDR_W'(pad);
        else out_status_nxt = ST_OVERSIZE;
      end
      S_F_READ: out_freed_nxt = FREED_W'(freed_r);
      default: ;
    endcase
  end

  // memory reads
  always_ff @(posedge clk) begin
    fill_rd <= fill_mem[fill_ra];
    tag_rd  <= tag_mem[ul_rd];
    ul_rd   <= ul_mem[ul_ra];
    fs_rd   <= fs_mem[fs_ra];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state_r == S_A_FIT && fits_act) begin
      fill_mem[cpage_r[c_r]] <= FW'(sum_act);
    end else if (state_r == S_N_FIT && fits_new) begin
      fill_mem[newp_r] <= FW'(sum_new);
    end
    if (state_r == S_N_FIT && fits_new) begin
      tag_mem[newp_r] <= tag_r;
    end
    if (state_r == S_N_FIT && fits_new && used_count_r < NUM_PAGES_C) begin
      ul_mem[PW'(used_count_r)] <= newp_r;
    end else if (state_r == S_F_LAST) begin
      ul_mem[PW'(walk_i_r)] <= ul_rd;
    end
    if (state_r == S_F_CHK && tag_hit && free_count_r < NUM_PAGES_C) begin
      fs_mem[PW'(free_count_r)] <= newp_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      c_r    <= cidx;
      tag_r  <= in_tag;
      size_r <= in_size_bytes;
      lg_r   <= in_align_log2;
      pa_r   <= ADDR_W'(base_r) + ADDR_W'(cpage_r[cidx]) * PAGE_ADDR;
    end
    if (state_r == S_A_LOOK) addr_r <= pa_r + ADDR_W'(fill_rd);
    if (state_r == S_N_ADDR) begin
      addr_r       <= ADDR_W'(base_r) + ADDR_W'(cand_p) * PAGE_ADDR;
      newp_r       <= cand_p;
      from_stack_r <= have_stack;
    end
    if (state_r == S_F_TAG) newp_r <= ul_rd;
    out_status_r  <= out_status_nxt;
    out_address_r <= out_address_nxt;
    out_freed_r   <= out_freed_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= '0;
      used_count_r <= '0;
      free_count_r <= '0;
      fresh_next_r <= '0;
      walk_i_r     <= '0;
      freed_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < NUM_CACHES; k++) begin
        cvalid_r[k] <= 1'b0;
        cpage_r[k]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) base_r <= cfg_data;
      out_valid_r <= ((state_r == S_IDLE) && accept && in_operation == OP_ALLOC && oversize)
                  || ((state_r == S_A_FIT) && fits_act)
                  || ((state_r == S_N_ADDR) && !have_stack && !have_fresh)
                  || (state_r == S_N_FIT)
                  || ((state_r == S_F_READ) && !(walk_i_r < used_count_r));
      if (accept && in_operation == OP_FREE) begin
        walk_i_r <= '0;
        freed_r  <= '0;
      end
      // new page taken
      if (state_r == S_N_FIT && fits_new) begin
        if (from_stack_r) free_count_r <= free_count_r - 1'b1;
        else fresh_next_r <= fresh_next_r + 1'b1;
        if (used_count_r < NUM_PAGES_C) used_count_r <= used_count_r + 1'b1;
        cvalid_r[c_r] <= 1'b1;
        cpage_r[c_r]  <= newp_r;
      end
      // free walk step
      if (state_r == S_F_CHK) begin
        if (tag_hit) begin
          if (free_count_r < NUM_PAGES_C) free_count_r <= free_count_r + 1'b1;
          used_count_r <= used_count_r - 1'b1;
          freed_r      <= freed_r + 1'b1;
          for (int k = 0; k < NUM_CACHES; k++) begin
            if (cvalid_r[k] && cpage_r[k] == newp_r) cvalid_r[k] <= 1'b0;
          end
        end else begin
          walk_i_r <= walk_i_r + 1'b1;
        end
      end
    end
  end

  // every page handed out is either in use or on the free stack
  a_page_count: assert property (@(posedge clk) disable iff (!rst_n)
    (busy == 1'b0) |-> (used_count_r + free_count_r == fresh_next_r))
    else $error("page accounting broken");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r <= NUM_PAGES_C)
    else $error("used count overflow");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(accept)))
    else $error("result without an item");

  a_active_page_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_LOOK) |-> (PW + 1)'(cpage_r[c_r]) < fresh_next_r)
    else $error("active page never handed out");

endmodule
